FILE: rtl/acs_pkg.sv
// Shared types, codes and arithmetic helpers of the AABB collision step unit.
`default_nettype none

package acs_pkg;

    // Field widths
    localparam int POS_W  = 24;             // Q15.8 coordinate
    localparam int EXT_W  = 26;             // headroom for four-term sums
    localparam int HALF_W = 16;             // Q8.8 half edge length
    localparam int CNT_W  = 7;              // body_count register
    localparam int CFG_W  = 16;             // widest configuration register

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [EXT_W-1:0] t_ext;

    localparam t_pos POS_MAX = 24'sh7FFFFF;
    localparam t_pos POS_MIN = 24'sh800000;

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd384;   // 1.5 in Q8.8

    // Configuration register indexes
    localparam logic CFG_BODY_COUNT  = 1'b0;
    localparam logic CFG_HALF_EXTENT = 1'b1;

    // Opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Memory address source
    typedef enum logic [1:0] {
        ADDR_IN   = 2'd0,
        ADDR_IDX  = 2'd1,
        ADDR_SLOT = 2'd2
    } t_addr_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic      capture;     // latch step operands
        logic      load_pos;    // latch own position from memory
        logic      load_trial;  // form trial position, clear flags and scan
        logic      scan;        // issue one body read per cycle
        logic      wb;          // resolve motion, write back, present result
        logic      load_wr;     // write a load transaction to memory
        t_addr_sel addr_sel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic idx_done;         // every active slot has been read
        logic cmp_vld;          // a compare is still in flight
    } t_status;

    // Sign-extend a coordinate to the working width
    function automatic t_ext sx(input t_pos v);
        return {{(EXT_W-POS_W){v[POS_W-1]}}, v};
    endfunction

    // Saturate a working-width sum to the Q15.8 range
    function automatic t_pos sat_pos(input t_ext v);
        if ((&v[EXT_W-1:POS_W-1]) || !(|v[EXT_W-1:POS_W-1])) begin
            return v[POS_W-1:0];
        end else if (v[EXT_W-1]) begin
            return POS_MIN;
        end else begin
            return POS_MAX;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acs_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module acs_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read one address per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/acs_ctrl.sv
// Controller state machine of the AABB collision step unit.
`default_nettype none

module acs_ctrl
    import acs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_start,
    input  wire logic    i_opcode,
    input  wire t_status i_status,
    output t_cmd         o_cmd,
    output logic         o_busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SELF  = 5'b00010,
        S_TRIAL = 5'b00100,
        S_SCAN  = 5'b01000,
        S_WB    = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start && (i_opcode == OP_STEP)) begin
                    n_state = S_SELF;
                end
            end
            S_SELF:  n_state = S_TRIAL;
            S_TRIAL: n_state = S_SCAN;
            S_SCAN: begin
                if (i_status.idx_done && !i_status.cmp_vld) begin
                    n_state = S_WB;
                end
            end
            S_WB:    n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode commands
    always_comb begin
        o_cmd = '0;
        o_cmd.addr_sel = ADDR_IN;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_start && (i_opcode == OP_STEP);
                o_cmd.load_wr = i_start && (i_opcode == OP_LOAD);
            end
            S_SELF:  o_cmd.load_pos = 1'b1;
            S_TRIAL: o_cmd.load_trial = 1'b1;
            S_SCAN: begin
                o_cmd.scan     = 1'b1;
                o_cmd.addr_sel = ADDR_IDX;
            end
            S_WB: begin
                o_cmd.wb       = 1'b1;
                o_cmd.addr_sel = ADDR_SLOT;
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/acs_dp.sv
// Datapath of the AABB collision step unit: body store, trial, compare, resolve.
`default_nettype none

module acs_dp
    import acs_pkg::*;
#(
    parameter int MAX_BODIES = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_status                o_status,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_addr,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic [5:0]        i_body_index,
    input  wire t_pos              i_load_x,
    input  wire t_pos              i_load_y,
    input  wire t_pos              i_load_z,
    input  wire t_pos              i_fall_speed,
    input  wire t_pos              i_jump_speed,
    input  wire t_pos              i_move_x,
    input  wire t_pos              i_move_y,
    input  wire t_pos              i_move_z,
    output t_pos                   o_new_x,
    output t_pos                   o_new_y,
    output t_pos                   o_new_z,
    output logic                   o_stop_fall,
    output logic                   o_stop_jump,
    output logic                   o_stop_move,
    output logic                   o_done
);

    localparam int AW     = $clog2(MAX_BODIES);
    localparam int CW     = $clog2(MAX_BODIES + 1);
    localparam int WORD_W = 3 * POS_W;

    // Configuration
    logic [CNT_W-1:0]  r_body_count;
    logic [HALF_W-1:0] r_half_extent;

    // Step operands and working state
    logic [5:0]  r_slot;
    logic        r_slot_ok;
    t_pos        r_fall, r_jump;
    t_pos        r_mv    [3];
    t_pos        r_pos   [3];
    t_pos        r_trial [3];
    logic [CW-1:0] r_idx, r_cmp_idx;
    logic        r_cmp_vld;
    logic        r_sf, r_sj, r_sm;

    // Result
    t_pos        r_new [3];
    logic        r_out_sf, r_out_sj, r_out_sm;
    logic        r_done;

    // Memory port
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;

    logic [CW-1:0] active_cnt;
    logic          in_slot_ok;
    t_pos          other [3];
    t_ext          d     [3];
    logic [2:0]    axis_hit;
    t_ext          two_h, neg_two_h, dy_pos;
    logic          is_self, hit;
    t_ext          res   [3];
    t_pos          res_sat [3];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_count  <= '0;
            r_half_extent <= HALF_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BODY_COUNT:  r_body_count  <= i_cfg_wdata[CNT_W-1:0];
                CFG_HALF_EXTENT: r_half_extent <= i_cfg_wdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the active count to the store depth
    assign active_cnt = (32'(r_body_count) > MAX_BODIES) ? CW'(MAX_BODIES)
                                                         : CW'(r_body_count);
    assign in_slot_ok = (32'(i_body_index) < MAX_BODIES);

    // Select memory address and write data
    always_comb begin
        case (i_cmd.addr_sel)
            ADDR_IN:   ram_addr = AW'(i_body_index);
            ADDR_IDX:  ram_addr = r_idx[AW-1:0];
            ADDR_SLOT: ram_addr = AW'(r_slot);
            default:   ram_addr = AW'(i_body_index);
        endcase
        if (i_cmd.load_wr) begin
            ram_we    = in_slot_ok;
            ram_wdata = {i_load_z, i_load_y, i_load_x};
        end else begin
            ram_we    = i_cmd.wb && r_slot_ok;
            ram_wdata = {res_sat[2], res_sat[1], res_sat[0]};
        end
    end

    acs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BODIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Compare the trial box with the body just read
    always_comb begin
        two_h     = t_ext'({1'b0, r_half_extent, 1'b0});
        neg_two_h = -two_h;
        for (int k = 0; k < 3; k++) begin
            other[k]    = ram_rdata[k*POS_W +: POS_W];
            d[k]        = sx(r_trial[k]) - sx(other[k]);
            axis_hit[k] = (d[k] <= two_h) && (d[k] >= neg_two_h);
        end
        dy_pos  = sx(r_pos[1]) - sx(other[1]);
        is_self = r_slot_ok && (32'(r_cmp_idx) == 32'(r_slot));
        hit     = r_cmp_vld && !is_self && (&axis_hit);
    end

    // Apply only the unblocked displacements
    always_comb begin
        res[0] = sx(r_pos[0]) + (r_sm ? t_ext'(0) : sx(r_mv[0]));
        res[1] = sx(r_pos[1]) - (r_sf ? t_ext'(0) : sx(r_fall))
                              + (r_sj ? t_ext'(0) : sx(r_jump))
                              + (r_sm ? t_ext'(0) : sx(r_mv[1]));
        res[2] = sx(r_pos[2]) + (r_sm ? t_ext'(0) : sx(r_mv[2]));
        for (int k = 0; k < 3; k++) begin
            res_sat[k] = sat_pos(res[k]);
        end
    end

    // Latch operands, own position and trial position
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_slot    <= i_body_index;
            r_slot_ok <= in_slot_ok;
            r_fall    <= i_fall_speed;
            r_jump    <= i_jump_speed;
            r_mv[0]   <= i_move_x;
            r_mv[1]   <= i_move_y;
            r_mv[2]   <= i_move_z;
        end
        if (i_cmd.load_pos) begin
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= r_slot_ok ? t_pos'(ram_rdata[k*POS_W +: POS_W]) : t_pos'(0);
            end
        end
        if (i_cmd.load_trial) begin
            r_trial[0] <= sat_pos(sx(r_pos[0]) + sx(r_mv[0]));
            r_trial[1] <= sat_pos(sx(r_pos[1]) - sx(r_fall) + sx(r_jump) + sx(r_mv[1]));
            r_trial[2] <= sat_pos(sx(r_pos[2]) + sx(r_mv[2]));
        end
    end

    // Advance the scan and hold the read pipeline tag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_idx <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.load_trial) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_idx != active_cnt) begin
                r_idx     <= r_idx + 1'b1;
                r_cmp_idx <= r_idx;
                r_cmp_vld <= 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end
        end
    end

    // Collect blocking flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_trial) begin
            r_sf <= 1'b0;
            r_sj <= 1'b0;
            r_sm <= 1'b0;
        end else if (hit) begin
            if (dy_pos > two_h) begin
                r_sf <= 1'b1;
            end else if (dy_pos < neg_two_h) begin
                r_sj <= 1'b1;
            end else begin
                r_sm <= 1'b1;
            end
        end
    end

    // Register the result transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.wb) begin
            for (int k = 0; k < 3; k++) begin
                r_new[k] <= res_sat[k];
            end
            r_out_sf <= r_sf;
            r_out_sj <= r_sj;
            r_out_sm <= r_sm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.wb;
        end
    end

    assign o_status.idx_done = (r_idx == active_cnt);
    assign o_status.cmp_vld  = r_cmp_vld;

    assign o_new_x     = r_new[0];
    assign o_new_y     = r_new[1];
    assign o_new_z     = r_new[2];
    assign o_stop_fall = r_out_sf;
    assign o_stop_jump = r_out_sj;
    assign o_stop_move = r_out_sm;
    assign o_done      = r_done;

endmodule

`default_nettype wire

FILE: rtl/aabb_collision_step_unit.sv
// Top level of the AABB collision step unit: controller plus datapath.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start high
//   and busy low. A load (opcode 0) writes one body position and leaves
//   busy low, so loads can follow every cycle; it gives no result.
//   A step (opcode 1) raises busy, reads the body's own position, forms the
//   trial position, then reads every active slot from the position store,
//   one memory read per cycle, and compares it on all three axes.
//   Result: o_done is high for exactly one cycle with the resolved position
//   and the three stop flags; the receiver cannot stall and must take it.
//   Timing: with N = min(body_count, MAX_BODIES), busy is high from the
//   accepted step through the own-position read, the trial, the scan of N
//   slots over the store's single read port and the write-back. o_done is
//   registered from the write-back; a command may be taken while it is shown.
//   Configuration: write body_count (index 0) or half_extent (index 1) with
//   i_cfg_we while the unit is idle.
//   Reset: synchronous, active low; clears the controller, the scan state
//   and body_count and sets half_extent to 1.5. The position store is not
//   cleared: load a slot before stepping it or comparing against it.
`default_nettype none

module aabb_collision_step_unit
    import acs_pkg::*;
#(
    parameter int MAX_BODIES = 64
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_addr,
    input  wire logic [CFG_W-1:0] i_cfg_wdata,
    input  wire logic             i_opcode,
    input  wire logic [5:0]       i_body_index,
    input  wire t_pos             i_load_x,
    input  wire t_pos             i_load_y,
    input  wire t_pos             i_load_z,
    input  wire t_pos             i_fall_speed,
    input  wire t_pos             i_jump_speed,
    input  wire t_pos             i_move_x,
    input  wire t_pos             i_move_y,
    input  wire t_pos             i_move_z,
    output logic                  o_done,
    output t_pos                  o_new_x,
    output t_pos                  o_new_y,
    output t_pos                  o_new_z,
    output logic                  o_stop_fall,
    output logic                  o_stop_jump,
    output logic                  o_stop_move
);

    t_cmd    cmd;
    t_status status;
    logic    ctrl_busy;

    // Sequence each transaction
    acs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (ctrl_busy)
    );

    // Store, compare and resolve
    acs_dp #(
        .MAX_BODIES (MAX_BODIES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_body_index (i_body_index),
        .i_load_x     (i_load_x),
        .i_load_y     (i_load_y),
        .i_load_z     (i_load_z),
        .i_fall_speed (i_fall_speed),
        .i_jump_speed (i_jump_speed),
        .i_move_x     (i_move_x),
        .i_move_y     (i_move_y),
        .i_move_z     (i_move_z),
        .o_new_x      (o_new_x),
        .o_new_y      (o_new_y),
        .o_new_z      (o_new_z),
        .o_stop_fall  (o_stop_fall),
        .o_stop_jump  (o_stop_jump),
        .o_stop_move  (o_stop_move),
        .o_done       (o_done)
    );

    assign busy = ctrl_busy;

endmodule

`default_nettype wire

FILE: rtl/acs_checker.sv
// Port-level checker of the AABB collision step unit and its bind.
`default_nettype none

module acs_checker
    import acs_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_opcode,
    input wire logic o_done
);

    // A load transaction never occupies the unit
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_LOAD)) |=> !busy)
        else $error("load transaction raised busy");

    // A step transaction always occupies the unit
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_STEP)) |=> busy)
        else $error("step transaction did not raise busy");

    // Busy ends only with a result
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_done)
        else $error("busy dropped without a result");

    // A result is shown while idle, for one cycle only
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy ##1 !o_done))
        else $error("result strobe overlaps busy or lasts too long");

endmodule

bind aabb_collision_step_unit acs_checker u_chk (.*);

`default_nettype wire
